>>> rtl/core/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the sorted priority task table
// Table size, field widths, command and status codes, and the item structs.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int NameW = 64;
  localparam int PrioW = 16;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdDelete = 2'd1;
  localparam logic [1:0] CmdLookup = 2'd2;
  localparam logic [1:0] CmdRead   = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEmpty    = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StBadPrio  = 3'd4;
  localparam logic [2:0] StBadPos   = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] name_tag;
    logic [15:0] new_priority;
    logic [5:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_name;
    logic [15:0] found_priority;
    logic [6:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [NameW-1:0] name;
    logic [PrioW-1:0] prio;
  } entry_t;

endpackage

>>> rtl/core/spt_ram.sv
// ----------------------------------------------------------------------------
// spt_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/sorted_priority_task_table_top.sv
// Throughput: one command at a time; the table walk reads one entry per cycle
// through the single read port of the entry RAM and, for insert and delete,
// moves it through its write port.
// Reset: asynchronous, active low; the table comes up empty, RAM contents are
// not cleared (entries beyond the count are never read).
// ----------------------------------------------------------------------------
// sorted_priority_task_table_top: sorted list priority queue
// Keeps entries ordered by priority, highest first, and serves insert,
// delete by name, lookup by name and read by position, at most one walk per command.
// ----------------------------------------------------------------------------
module sorted_priority_task_table_top
  import spt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_SCAN,
    S_READ,
    S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [NameW-1:0] tag_q, tag_d;
  logic [PrioW-1:0] prio_q, prio_d;
  logic [PrioW-1:0] head_prio_q, head_prio_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             found_q, found_d;
  logic [2:0]       status_q, status_d;
  logic [NameW-1:0] fname_q, fname_d;
  logic [PrioW-1:0] fprio_q, fprio_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic [CntW-1:0]  cnt_m1;
  logic [PrioW-1:0] in_prio;
  logic             move;
  logic             hit;
  logic             last;
  logic             accept;

  spt_ram #(
    .Width ($bits(entry_t)),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign cnt_m1  = count_q - CntW'(1);
  assign in_prio = in_item_i.new_priority[PrioW-1:0];
  // the table is kept non-increasing, so the walk from the tail stops at
  // the first entry that must stay; a priority at or above the head's
  // moves every entry
  assign move = (prio_q >= head_prio_q) || (ram_rdata.prio < prio_q);
  assign hit  = (ram_rdata.name == tag_q);
  assign last = ({1'b0, idx_q} == cnt_m1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    tag_d       = tag_q;
    prio_d      = prio_q;
    head_prio_d = head_prio_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    status_d    = status_q;
    fname_d     = fname_q;
    fprio_d     = fprio_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = in_item_i.cmd;
          tag_d    = in_item_i.name_tag;
          prio_d   = in_prio;
          status_d = StOk;
          fname_d  = '0;
          fprio_d  = '0;
          found_d  = 1'b0;
          state_d  = S_RESP;
          case (in_item_i.cmd)
            CmdInsert: begin
              if (in_prio == '0) begin
                status_d = StBadPrio;
              end else if (count_q == CntW'(Depth)) begin
                status_d = StFull;
              end else if (count_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{name: in_item_i.name_tag, prio: in_prio};
                count_d   = CntW'(1);
              end else begin
                ram_raddr = cnt_m1[AddrW-1:0];
                idx_d     = cnt_m1[AddrW-1:0];
                state_d   = S_INS;
              end
            end
            CmdDelete, CmdLookup: begin
              if (count_q == '0) begin
                status_d = StEmpty;
              end else begin
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_SCAN;
              end
            end
            CmdRead: begin
              if (count_q == '0) begin
                status_d = StEmpty;
              end else if ({1'b0, in_item_i.position} >= count_q) begin
                status_d = StBadPos;
              end else begin
                ram_raddr = in_item_i.position[AddrW-1:0];
                state_d   = S_READ;
              end
            end
            default: begin
              status_d = StOk;
            end
          endcase
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + AddrW'(1);
        if (move) begin
          // shift this entry down one place and fetch the one above it, if any
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            ram_raddr = idx_q - AddrW'(1);
            idx_d     = idx_q - AddrW'(1);
          end
        end else begin
          ram_wdata = '{name: tag_q, prio: prio_q};
          count_d   = count_q + CntW'(1);
          state_d   = S_RESP;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{name: tag_q, prio: prio_q};
        count_d   = count_q + CntW'(1);
        state_d   = S_RESP;
      end

      S_SCAN: begin
        if (cmd_q == CmdLookup) begin
          if (hit) begin
            fname_d = ram_rdata.name;
            fprio_d = ram_rdata.prio;
            state_d = S_RESP;
          end else if (last) begin
            status_d = StNotFound;
            state_d  = S_RESP;
          end else begin
            ram_raddr = idx_q + AddrW'(1);
            idx_d     = idx_q + AddrW'(1);
          end
        end else begin
          if (found_q) begin
            // close the gap left by the deleted entry
            ram_we    = 1'b1;
            ram_waddr = idx_q - AddrW'(1);
            ram_wdata = ram_rdata;
          end else if (hit) begin
            found_d = 1'b1;
            fprio_d = ram_rdata.prio;
          end
          if (last) begin
            if (found_q || hit) begin
              count_d = cnt_m1;
            end else begin
              status_d = StNotFound;
            end
            state_d = S_RESP;
          end else begin
            ram_raddr = idx_q + AddrW'(1);
            idx_d     = idx_q + AddrW'(1);
          end
        end
      end

      S_READ: begin
        fname_d = ram_rdata.name;
        fprio_d = ram_rdata.prio;
        state_d = S_RESP;
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.status         = status_q;
          out_d.found_name     = fname_q;
          out_d.found_priority = 16'(fprio_q);
          out_d.entry_count    = 7'(count_q);
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // track the head priority for the insert walk
    if (ram_we && ram_waddr == '0) begin
      head_prio_d = ram_wdata.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CmdInsert;
      tag_q       <= '0;
      prio_q      <= '0;
      head_prio_q <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      status_q    <= StOk;
      fname_q     <= '0;
      fprio_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      tag_q       <= tag_d;
      prio_q      <= prio_d;
      head_prio_q <= head_prio_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      found_q     <= found_d;
      status_q    <= status_d;
      fname_q     <= fname_d;
      fprio_q     <= fprio_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted command did not start");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (count_q != '0 && count_q < CntW'(Depth)))
    else $error("insert walk on empty or full table");

  a_resp_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> !ram_we)
    else $error("table written while answering");

endmodule
